// File: design/json_token_lexer_defines.svh
// ----------------------------------------------------------------------------
// json_token_lexer_defines: assertion macros for the JSON token lexer
// Same-cycle and next-cycle implication checks clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef JSON_TOKEN_LEXER_DEFINES_SVH
`define JSON_TOKEN_LEXER_DEFINES_SVH

// check cons in the same cycle as ante
`define JTL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define JTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/jtl_pkg.sv
// ----------------------------------------------------------------------------
// jtl_pkg: types and constants of the JSON token lexer
// Token kind codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package jtl_pkg;

  localparam logic [3:0] KIND_LBRACE = 4'd0;
  localparam logic [3:0] KIND_RBRACE = 4'd1;
  localparam logic [3:0] KIND_LBRACK = 4'd2;
  localparam logic [3:0] KIND_RBRACK = 4'd3;
  localparam logic [3:0] KIND_COMMA  = 4'd4;
  localparam logic [3:0] KIND_COLON  = 4'd5;
  localparam logic [3:0] KIND_STRING = 4'd6;
  localparam logic [3:0] KIND_NUMBER = 4'd7;
  localparam logic [3:0] KIND_IDENT  = 4'd8;
  localparam logic [3:0] KIND_ERROR  = 4'd9;
  localparam logic [3:0] KIND_END    = 4'd10;

  localparam logic REG_QUOTE_FIRST  = 1'b0;
  localparam logic REG_QUOTE_SECOND = 1'b1;

  localparam logic [7:0] QUOTE_FIRST_RESET  = 8'd34;
  localparam logic [7:0] QUOTE_SECOND_RESET = 8'd39;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [3:0]  kind;
    logic        has;
    logic [7:0]  ch;
    logic        first;
    logic        fin;
    logic [15:0] pos;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// File: design/json_token_lexer.sv
// Each text byte is registered in the input stage, its results in the result queue.
// Throughput: one text byte per cycle; a byte that ends a number or identifier and
// opens a non-string token gives two results, which leave one per ready cycle via
// a four-entry result queue that holds the input stage while it lacks two slots.
// Reset (rst, synchronous): lexer idle, position zero, queue empty, quotes 34/39.
// ----------------------------------------------------------------------------
// json_token_lexer: streaming JSON tokeniser
// Classifies one registered text byte per cycle against the lexer mode, while
// the queue has two free slots, and queues the resulting token transactions.
// ----------------------------------------------------------------------------
`default_nettype none
`include "json_token_lexer_defines.svh"

module json_token_lexer
  import jtl_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tlast,   // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] token_char, [8] token_first,
                                           // [9] token_end, [25:10] text_position
  output logic [7:0]       m_axis_tuser,   // [3:0] token_kind, [4] has_byte
  output logic             m_axis_tlast    // last
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_ERROR
  } mode_t;

  localparam int PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

  logic [7:0] quote_first;
  logic [7:0] quote_second;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eot;

  mode_t                    mode, mode_next;
  logic [7:0]               closing_quote, closing_quote_next;
  logic                     first_pending, first_pending_next;
  logic [POSITION_BITS-1:0] byte_count, byte_count_next, byte_count_inc;

  result_t             fifo [FIFO_DEPTH];
  logic [PTR_BITS-1:0] rd_ptr, wr_ptr;
  logic [CNT_BITS-1:0] count;

  logic          eot, fire, pop;
  logic [1:0]    push_n;
  result_t       res0, res1;
  logic [31:0]   pos_wide;
  logic [15:0]   pos_now;
  logic          is_space, is_digit, is_letter, is_quote, is_punct;
  logic [3:0]    punct_kind;
  logic          st_emit;
  result_t       st_res;
  mode_t         st_mode;
  logic          st_string;
  logic          st_token;

  assign eot  = in_eot || (in_byte == CHAR_NUL);
  assign fire = in_valid && (count <= CNT_BITS'(FIFO_DEPTH - 2));
  assign pop  = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = !in_valid || fire;

  assign byte_count_inc = (byte_count == {POSITION_BITS{1'b1}}) ? byte_count
                          : byte_count + POSITION_BITS'(1);
  assign pos_wide = eot ? 32'(byte_count) : 32'(byte_count_inc);
  assign pos_now  = pos_wide[15:0];

  // classify the held byte
  always_comb begin
    is_space  = (in_byte == CHAR_SPACE) || (in_byte == CHAR_TAB) ||
                (in_byte == CHAR_CR) || (in_byte == CHAR_LF);
    is_digit  = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    is_letter = ((in_byte >= 8'h41) && (in_byte <= 8'h5A)) ||
                ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) || (in_byte == CHAR_UNDER);
    is_quote  = (in_byte == quote_first) || (in_byte == quote_second);
    is_punct  = 1'b1;
    case (in_byte)
      8'h7B: punct_kind = KIND_LBRACE;
      8'h7D: punct_kind = KIND_RBRACE;
      8'h5B: punct_kind = KIND_LBRACK;
      8'h5D: punct_kind = KIND_RBRACK;
      8'h2C: punct_kind = KIND_COMMA;
      8'h3A: punct_kind = KIND_COLON;
      default: begin
        punct_kind = KIND_ERROR;
        is_punct   = 1'b0;
      end
    endcase
  end

  // token start from idle
  always_comb begin
    st_emit   = 1'b0;
    st_mode   = MODE_IDLE;
    st_string = 1'b0;
    st_token  = 1'b0;
    st_res    = '{kind: KIND_ERROR, has: 1'b1, ch: in_byte, first: 1'b1, fin: 1'b1,
                  pos: pos_now, last: 1'b0};
    if (is_space) begin
      st_mode = MODE_IDLE;
    end else if (is_punct) begin
      st_emit     = 1'b1;
      st_res.kind = punct_kind;
    end else if (is_quote) begin
      st_mode   = MODE_STRING;
      st_string = 1'b1;
    end else if (is_digit) begin
      st_emit     = 1'b1;
      st_mode     = MODE_NUMBER;
      st_token    = 1'b1;
      st_res.kind = KIND_NUMBER;
      st_res.fin  = 1'b0;
    end else if (is_letter) begin
      st_emit     = 1'b1;
      st_mode     = MODE_IDENT;
      st_token    = 1'b1;
      st_res.kind = KIND_IDENT;
      st_res.fin  = 1'b0;
    end else begin
      st_emit = 1'b1;
      st_mode = MODE_ERROR;
    end
  end

  // lexer step
  always_comb begin
    mode_next          = mode;
    closing_quote_next = closing_quote;
    first_pending_next = first_pending;
    byte_count_next    = byte_count;
    push_n             = 2'd0;
    res0 = '{kind: KIND_END, has: 1'b0, ch: 8'h00, first: 1'b0, fin: 1'b1,
             pos: pos_now, last: 1'b0};
    res1 = res0;
    if (eot) begin
      byte_count_next    = '0;
      mode_next          = MODE_IDLE;
      first_pending_next = 1'b0;
      case (mode)
        MODE_STRING: begin
          res0.kind  = KIND_STRING;
          res0.first = first_pending;
          push_n     = 2'd1;
        end
        MODE_NUMBER: begin
          res0.kind = KIND_NUMBER;
          push_n    = 2'd1;
        end
        MODE_IDENT: begin
          res0.kind = KIND_IDENT;
          push_n    = 2'd1;
        end
        default: push_n = 2'd0;
      endcase
      if (push_n == 2'd1) begin
        res1.first = 1'b1;
        res1.last  = 1'b1;
        push_n     = 2'd2;
      end else begin
        res0.first = 1'b1;
        res0.last  = 1'b1;
        push_n     = 2'd1;
      end
    end else begin
      byte_count_next = byte_count_inc;
      case (mode)
        MODE_STRING: begin
          res0.kind  = KIND_STRING;
          res0.first = first_pending;
          res0.last  = 1'b1;
          push_n     = 2'd1;
          if (in_byte == closing_quote) begin
            mode_next = MODE_IDLE;
          end else begin
            res0.has = 1'b1;
            res0.ch  = in_byte;
            res0.fin = 1'b0;
          end
          first_pending_next = 1'b0;
        end
        MODE_NUMBER, MODE_IDENT: begin
          res0.kind = (mode == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
          push_n    = 2'd1;
          if (is_digit || ((mode == MODE_NUMBER) && (in_byte == CHAR_DOT)) ||
              ((mode == MODE_IDENT) && is_letter)) begin
            res0.has  = 1'b1;
            res0.ch   = in_byte;
            res0.fin  = 1'b0;
            res0.last = 1'b1;
          end else begin
            mode_next = st_mode;
            if (st_string) begin
              closing_quote_next = in_byte;
              first_pending_next = 1'b1;
            end else if (st_token) begin
              first_pending_next = 1'b0;
            end
            if (st_emit) begin
              res1      = st_res;
              res1.last = 1'b1;
              push_n    = 2'd2;
            end else begin
              res0.last = 1'b1;
            end
          end
        end
        MODE_ERROR: push_n = 2'd0;
        default: begin
          mode_next = st_mode;
          if (st_string) begin
            closing_quote_next = in_byte;
            first_pending_next = 1'b1;
          end else if (st_token) begin
            first_pending_next = 1'b0;
          end
          res0      = st_res;
          res0.last = 1'b1;
          push_n    = st_emit ? 2'd1 : 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_first  <= QUOTE_FIRST_RESET;
      quote_second <= QUOTE_SECOND_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_QUOTE_FIRST) begin
        quote_first <= cfg_data;
      end else begin
        quote_second <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_eot  <= s_axis_tlast;
    end
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      closing_quote <= 8'h00;
      first_pending <= 1'b0;
      byte_count    <= '0;
    end else if (fire) begin
      mode          <= mode_next;
      closing_quote <= closing_quote_next;
      first_pending <= first_pending_next;
      byte_count    <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (push_n != 2'd0)) begin
      fifo[wr_ptr] <= res0;
    end
    if (fire && (push_n == 2'd2)) begin
      fifo[wr_ptr + PTR_BITS'(1)] <= res1;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (fire) begin
        wr_ptr <= wr_ptr + PTR_BITS'(push_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + (fire ? CNT_BITS'(push_n) : CNT_BITS'(0)) - CNT_BITS'(pop);
    end
  end

  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {6'd0, fifo[rd_ptr].pos, fifo[rd_ptr].fin,
                          fifo[rd_ptr].first, fifo[rd_ptr].ch};
  assign m_axis_tuser  = {3'd0, fifo[rd_ptr].has, fifo[rd_ptr].kind};
  assign m_axis_tlast  = fifo[rd_ptr].last;

  `JTL_ASSERT_NOW(a_queue_bound, 1'b1, count <= CNT_BITS'(FIFO_DEPTH),
    "result queue overfilled")
  `JTL_ASSERT_NEXT(a_eot_clears, fire && eot, byte_count == '0 && mode == MODE_IDLE,
    "end of text did not clear the lexer")
  `JTL_ASSERT_NOW(a_end_is_last, m_axis_tvalid && (m_axis_tuser[3:0] == KIND_END),
    m_axis_tlast && m_axis_tdata[8] && m_axis_tdata[9] && !m_axis_tuser[4],
    "end marker malformed")
  `JTL_ASSERT_NEXT(a_error_silent, fire && !eot && (mode == MODE_ERROR),
    count <= $past(count), "result produced in error mode")

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the JSON token lexer
// Drives JSON-like text byte by byte with bursty flow control, predicts every
// token transaction in a scoreboard and compares it field by field with the
// output stream, under several quote settings.
// ----------------------------------------------------------------------------

import jtl_pkg::*;

typedef enum logic [2:0] {LEX_IDLE, LEX_STR, LEX_NUM, LEX_IDENT, LEX_ERR} lex_mode_e;

class token_scoreboard;
  logic [7:0]  quote_a;
  logic [7:0]  quote_b;
  lex_mode_e   mode;
  logic [7:0]  close_q;
  logic        first_pend;
  logic [15:0] pos;
  result_t     step_buf [0:1];
  int          step_cnt;
  result_t     expected_tokens [$];
  int          errors;

  function new();
    quote_a    = QUOTE_FIRST_RESET;
    quote_b    = QUOTE_SECOND_RESET;
    mode       = LEX_IDLE;
    close_q    = '0;
    first_pend = 1'b0;
    pos        = '0;
    step_cnt   = 0;
    errors     = 0;
  endfunction

  function void set_quote(logic idx, logic [7:0] v);
    if (idx == REG_QUOTE_FIRST) quote_a = v;
    else quote_b = v;
  endfunction

  function int pending();
    return expected_tokens.size();
  endfunction

  function bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function bit is_letter(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == CHAR_UNDER;
  endfunction

  function bit is_blank(logic [7:0] b);
    return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR || b == CHAR_LF;
  endfunction

  function bit punct_kind(logic [7:0] b, output logic [3:0] k);
    punct_kind = 1'b1;
    k = KIND_LBRACE;
    case (b)
      "{": k = KIND_LBRACE;
      "}": k = KIND_RBRACE;
      "[": k = KIND_LBRACK;
      "]": k = KIND_RBRACK;
      ",": k = KIND_COMMA;
      ":": k = KIND_COLON;
      default: punct_kind = 1'b0;
    endcase
  endfunction

  function void add(logic [3:0] kind, logic has, logic [7:0] ch, logic first, logic fin);
    result_t r;
    r.kind  = kind;
    r.has   = has;
    r.ch    = has ? ch : 8'd0;
    r.first = first;
    r.fin   = fin;
    r.pos   = pos;
    r.last  = 1'b0;
    step_buf[step_cnt] = r;
    step_cnt++;
  endfunction

  function void open_token(logic [7:0] b);
    logic [3:0] k;
    if (is_blank(b)) begin
      return;
    end else if (punct_kind(b, k)) begin
      add(k, 1'b1, b, 1'b1, 1'b1);
    end else if (b == quote_a || b == quote_b) begin
      mode       = LEX_STR;
      close_q    = b;
      first_pend = 1'b1;
    end else if (is_digit(b)) begin
      mode = LEX_NUM;
      add(KIND_NUMBER, 1'b1, b, 1'b1, 1'b0);
      first_pend = 1'b0;
    end else if (is_letter(b)) begin
      mode = LEX_IDENT;
      add(KIND_IDENT, 1'b1, b, 1'b1, 1'b0);
      first_pend = 1'b0;
    end else begin
      mode = LEX_ERR;
      add(KIND_ERROR, 1'b1, b, 1'b1, 1'b1);
    end
  endfunction

  // predict the token transactions caused by one accepted text byte
  function void note_text(logic [7:0] b, logic eot);
    result_t r;
    step_cnt = 0;
    if (eot || b == CHAR_NUL) begin
      case (mode)
        LEX_STR:   add(KIND_STRING, 1'b0, 8'd0, first_pend, 1'b1);
        LEX_NUM:   add(KIND_NUMBER, 1'b0, 8'd0, 1'b0, 1'b1);
        LEX_IDENT: add(KIND_IDENT, 1'b0, 8'd0, 1'b0, 1'b1);
        default: ;
      endcase
      add(KIND_END, 1'b0, 8'd0, 1'b1, 1'b1);
      mode       = LEX_IDLE;
      first_pend = 1'b0;
      pos        = '0;
    end else begin
      if (pos != 16'hFFFF) pos++;
      case (mode)
        LEX_STR: begin
          if (b == close_q) begin
            add(KIND_STRING, 1'b0, 8'd0, first_pend, 1'b1);
            mode = LEX_IDLE;
          end else begin
            add(KIND_STRING, 1'b1, b, first_pend, 1'b0);
          end
          first_pend = 1'b0;
        end
        LEX_NUM: begin
          if (is_digit(b) || b == CHAR_DOT) begin
            add(KIND_NUMBER, 1'b1, b, 1'b0, 1'b0);
          end else begin
            add(KIND_NUMBER, 1'b0, 8'd0, 1'b0, 1'b1);
            mode = LEX_IDLE;
            open_token(b);
          end
        end
        LEX_IDENT: begin
          if (is_letter(b) || is_digit(b)) begin
            add(KIND_IDENT, 1'b1, b, 1'b0, 1'b0);
          end else begin
            add(KIND_IDENT, 1'b0, 8'd0, 1'b0, 1'b1);
            mode = LEX_IDLE;
            open_token(b);
          end
        end
        LEX_ERR: ;
        default: open_token(b);
      endcase
    end
    for (int i = 0; i < step_cnt; i++) begin
      r = step_buf[i];
      r.last = (i == step_cnt - 1);
      expected_tokens.push_back(r);
    end
  endfunction

  function void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_token(result_t got);
    result_t want;
    if (expected_tokens.size() == 0) begin
      $error("unexpected token transaction: kind %0d char %0d", got.kind, got.ch);
      errors++;
      return;
    end
    want = expected_tokens.pop_front();
    cmp_field("token_kind", 32'(want.kind), 32'(got.kind));
    cmp_field("has_byte", 32'(want.has), 32'(got.has));
    cmp_field("token_char", 32'(want.ch), 32'(got.ch));
    cmp_field("token_first", 32'(want.first), 32'(got.first));
    cmp_field("token_end", 32'(want.fin), 32'(got.fin));
    cmp_field("text_position", 32'(want.pos), 32'(got.pos));
    cmp_field("last", 32'(want.last), 32'(got.last));
  endfunction
endclass

module tb_top;
  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASE_ITEMS = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_QUOTE_FIRST;
  logic [7:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [31:0] m_axis_tdata;
  logic [7:0]  m_axis_tuser;
  logic        m_axis_tlast;

  token_scoreboard sb = new();

  int         burst_left = 0;
  int         items_sent = 0;
  logic [7:0] cur_q1 = QUOTE_FIRST_RESET;
  logic [7:0] cur_q2 = QUOTE_SECOND_RESET;
  int         ready_mode = 0;
  int         ready_cycle = 0;

  string puncts  = "{}[],:";
  string blanks  = " \t\r\n";
  string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";

  logic [7:0] q1_set [5] = '{8'h22, 8'h00, ":", "a", 8'hFF};
  logic [7:0] q2_set [5] = '{8'h27, 8'hFF, "5", " ", 8'h00};

  json_token_lexer u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // output side: check every transaction, stall on a pattern that is re-chosen at random
  always @(posedge clk) begin
    result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind  = m_axis_tuser[3:0];
      got.has   = m_axis_tuser[4];
      got.ch    = m_axis_tdata[7:0];
      got.first = m_axis_tdata[8];
      got.fin   = m_axis_tdata[9];
      got.pos   = m_axis_tdata[25:10];
      got.last  = m_axis_tlast;
      sb.check_token(got);
    end
    ready_cycle++;
    if (ready_cycle % 64 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 99) < 70);
      2: m_axis_tready <= (ready_cycle % 8) < 3;
      default: m_axis_tready <= ($urandom_range(0, 99) < 30);
    endcase
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_text(input logic [7:0] b, input logic eot);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_text(b, eot);
    items_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_text(s[i], 1'b0);
  endtask

  // hold the input idle until every token has left, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_quotes(input logic [7:0] q1, input logic [7:0] q2);
    cfg_write <= 1'b1;
    cfg_index <= REG_QUOTE_FIRST;
    cfg_data  <= q1;
    @(posedge clk);
    cfg_index <= REG_QUOTE_SECOND;
    cfg_data  <= q2;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_quote(REG_QUOTE_FIRST, q1);
    sb.set_quote(REG_QUOTE_SECOND, q2);
    cur_q1 = q1;
    cur_q2 = q2;
  endtask

  task automatic random_text();
    int         r;
    logic [7:0] q;
    repeat ($urandom_range(2, 16)) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_text(puncts[$urandom_range(0, 5)], 1'b0);
      end else if (r < 50) begin
        q = $urandom_range(0, 1) ? cur_q1 : cur_q2;
        if (q == CHAR_NUL) q = (cur_q1 == CHAR_NUL) ? cur_q2 : cur_q1;
        send_text(q, 1'b0);
        repeat ($urandom_range(0, 6)) send_text(8'($urandom_range(1, 255)), 1'b0);
        if ($urandom_range(0, 9) != 0) send_text(q, 1'b0);
      end else if (r < 65) begin
        send_text(8'($urandom_range("0", "9")), 1'b0);
        repeat ($urandom_range(0, 5))
          send_text($urandom_range(0, 4) == 0 ? CHAR_DOT : 8'($urandom_range("0", "9")),
                    1'b0);
      end else if (r < 80) begin
        send_text(letters[$urandom_range(0, letters.len() - 1)], 1'b0);
        repeat ($urandom_range(0, 5))
          send_text($urandom_range(0, 3) == 0 ? 8'($urandom_range("0", "9"))
                    : letters[$urandom_range(0, letters.len() - 1)], 1'b0);
      end else if (r < 94) begin
        repeat ($urandom_range(1, 3)) send_text(blanks[$urandom_range(0, 3)], 1'b0);
      end else begin
        send_text(8'($urandom_range(1, 255)), 1'b0);
      end
    end
    case ($urandom_range(0, 2))
      0: send_text(8'($urandom_range(0, 255)), 1'b1);
      1: send_text(CHAR_NUL, 1'b0);
      default: send_text(CHAR_NUL, 1'b1);
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 5; p++) begin
      set_quotes(q1_set[p], q2_set[p]);
      if (p == 0) begin
        // empty string, number cut by an identifier, identifier cut by punctuation
        send_str("{\"\":[7x,a_9]}");
        send_text(8'hFF, 1'b1);
        // string left open at a zero byte
        send_str("'ab");
        send_text(CHAR_NUL, 1'b0);
        // number cut by a tab, then an error and an ignored byte
        send_str(" 3.\t#q");
        send_text(8'h00, 1'b1);
      end
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) random_text();
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
